/* hw/rtl/twe_pkg.sv */
// ----------------------------------------------------------------------------
// twe_pkg
// Shared types, codes and defaults for the timer wheel expiry unit.
// ----------------------------------------------------------------------------
package twe_pkg;

  localparam int NUM_TIMERS_DEF  = 16;
  localparam int WHEEL_SLOTS_DEF = 60;

  localparam int ID_W  = 64;
  localparam int TMO_W = 10;
  localparam int REM_W = 8;
  localparam int EV_W  = 3;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_ADD     = 2'd1,
    OP_REFRESH = 2'd2,
    OP_CANCEL  = 2'd3
  } opcode_e;

  typedef enum logic [EV_W-1:0] {
    EV_DONE     = 3'd0,
    EV_FIRED    = 3'd1,
    EV_CANCELED = 3'd2,
    EV_UNKNOWN  = 3'd3,
    EV_REJECTED = 3'd4
  } event_e;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [ID_W-1:0]  task_id;
    logic [TMO_W-1:0] timeout_ticks;
  } in_req_t;

  typedef struct packed {
    logic [ID_W-1:0] task_id_out;
    logic [EV_W-1:0] event_res;
    logic            last;
  } out_rsp_t;

  typedef struct packed {
    logic             tick;
    logic             add;
    logic             refresh;
    logic             cancel;
    logic             take;
    logic [ID_W-1:0]  id;
    logic [REM_W-1:0] span;
  } ctrl_t;

  typedef struct packed {
    logic            free;
    logic            match;
    logic            rpt_hit;
    logic [ID_W-1:0] rpt_id;
    logic [EV_W-1:0] rpt_ev;
  } link_t;

endpackage

/* hw/rtl/twe_cell.sv */
// ----------------------------------------------------------------------------
// twe_cell
// One timer slot: id, remaining count, armed distance and cancel mark, with
// free, match and report links chained to its neighbors.
// ----------------------------------------------------------------------------
module twe_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  twe_pkg::ctrl_t ctrl_i,
  input  twe_pkg::link_t link_i,
  output twe_pkg::link_t link_o
);

  logic                      valid_q, valid_d;
  logic                      pend_q, pend_d;
  logic [twe_pkg::ID_W-1:0]  id_q;
  logic [twe_pkg::REM_W-1:0] rem_q;
  logic [twe_pkg::REM_W-1:0] tmo_q;
  logic                      canc_q;

  logic                      match;
  logic                      grab;
  logic                      sel;
  logic                      expire;
  logic [twe_pkg::REM_W-1:0] nrem;

  assign match  = valid_q && (id_q == ctrl_i.id);
  assign grab   = ctrl_i.add && !valid_q && !link_i.free;
  assign sel    = pend_q && !link_i.rpt_hit;
  assign nrem   = (rem_q != '0) ? rem_q - twe_pkg::REM_W'(1) : '0;
  assign expire = ctrl_i.tick && valid_q && (nrem == '0);

  always_comb begin
    link_o.free  = link_i.free | !valid_q;
    link_o.match = link_i.match | match;
    if (link_i.rpt_hit) begin
      link_o.rpt_hit = 1'b1;
      link_o.rpt_id  = link_i.rpt_id;
      link_o.rpt_ev  = link_i.rpt_ev;
    end else begin
      link_o.rpt_hit = pend_q;
      link_o.rpt_id  = id_q;
      link_o.rpt_ev  = canc_q ? twe_pkg::EV_CANCELED : twe_pkg::EV_FIRED;
    end
  end

  always_comb begin
    valid_d = valid_q;
    pend_d  = pend_q;
    if (grab) begin
      valid_d = 1'b1;
    end else if (expire) begin
      valid_d = 1'b0;
      pend_d  = 1'b1;
    end
    if (ctrl_i.take && sel) begin
      pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (grab) begin
      id_q   <= ctrl_i.id;
      tmo_q  <= ctrl_i.span;
      rem_q  <= ctrl_i.span;
      canc_q <= 1'b0;
    end else begin
      if (ctrl_i.tick && valid_q) begin
        rem_q <= nrem;
      end else if (ctrl_i.refresh && match && (tmo_q > rem_q)) begin
        rem_q <= tmo_q;
      end
      if (ctrl_i.cancel && match) begin
        canc_q <= 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/timer_wheel_expiry_unit.sv */
// ----------------------------------------------------------------------------
// timer_wheel_expiry_unit
// Hashed timing wheel kept as a row of timer cells: add, refresh, cancel and
// tick requests, with fired and canceled expiries reported in slot order.
//
//   channel   handshake              payload
//   request   in_valid_i/in_stall_o  in_req_i  (opcode, task_id, timeout_ticks)
//   result    out_valid_o/out_stall_i out_rsp_o (task_id_out, event_res, last)
//
// A request other than a tick has its result in the output register after
// the reciprocal multiply of the distance in S_CALC and the cell row lookup
// in S_EXEC. A tick steps the row in S_EXEC instead, then gives one expiry
// result per cycle while the output register is not stalled, lowest slot
// first, and a final done result. The next request is taken once the last
// result is in the output register and the unit is back in S_IDLE. A stalled
// full output register holds the row. Reset empties every slot at once.
// ----------------------------------------------------------------------------
module timer_wheel_expiry_unit #(
  parameter int NUM_TIMERS  = twe_pkg::NUM_TIMERS_DEF,
  parameter int WHEEL_SLOTS = twe_pkg::WHEEL_SLOTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  twe_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output twe_pkg::out_rsp_t out_rsp_o
);

  localparam int DIV_SHIFT = 20;
  localparam int PROD_W    = twe_pkg::TMO_W + DIV_SHIFT;
  localparam int DIV_MUL   = (1 << DIV_SHIFT) / WHEEL_SLOTS + 1;
  localparam int QW_W      = twe_pkg::TMO_W + twe_pkg::REM_W;
  localparam logic [twe_pkg::REM_W-1:0] SLOTS = twe_pkg::REM_W'(WHEEL_SLOTS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_EXEC,
    S_REPORT
  } state_e;

  state_e                    state_q;
  logic [1:0]                op_q;
  logic [twe_pkg::ID_W-1:0]  id_q;
  logic [twe_pkg::TMO_W-1:0] tmo_q;
  logic [twe_pkg::TMO_W-1:0] quo_q;
  logic                      out_valid_q;
  twe_pkg::out_rsp_t         out_rsp_q;

  logic [PROD_W-1:0]         prod;
  logic [QW_W-1:0]           qw;
  logic [QW_W-1:0]           rem_full;
  logic [twe_pkg::REM_W-1:0] span;
  logic                      out_free;
  logic                      out_load;
  logic                      exec_go;
  twe_pkg::ctrl_t            ctrl;
  twe_pkg::link_t            chain [NUM_TIMERS+1];

  assign prod     = PROD_W'(tmo_q) * PROD_W'(DIV_MUL);
  assign qw       = QW_W'(quo_q) * QW_W'(SLOTS);
  assign rem_full = QW_W'(tmo_q) - qw;
  assign span     = (rem_full[twe_pkg::REM_W-1:0] == '0) ? SLOTS
                                                         : rem_full[twe_pkg::REM_W-1:0];

  assign out_free = !out_valid_q || !out_stall_i;
  assign exec_go  = (state_q == S_EXEC) && out_free;
  assign out_load = out_free && (((state_q == S_EXEC) && (op_q != twe_pkg::OP_TICK)) ||
                                 (state_q == S_REPORT));

  always_comb begin
    ctrl.tick    = exec_go && (op_q == twe_pkg::OP_TICK);
    ctrl.add     = exec_go && (op_q == twe_pkg::OP_ADD) && !chain[NUM_TIMERS].match;
    ctrl.refresh = exec_go && (op_q == twe_pkg::OP_REFRESH);
    ctrl.cancel  = exec_go && (op_q == twe_pkg::OP_CANCEL);
    ctrl.take    = (state_q == S_REPORT) && out_free;
    ctrl.id      = id_q;
    ctrl.span    = span;
  end

  assign chain[0] = '0;

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    twe_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .link_i (chain[i]),
      .link_o (chain[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      op_q        <= '0;
      id_q        <= '0;
      tmo_q       <= '0;
      quo_q       <= '0;
      out_rsp_q   <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q    <= in_req_i.opcode;
            id_q    <= in_req_i.task_id;
            tmo_q   <= in_req_i.timeout_ticks;
            state_q <= S_CALC;
          end
        end
        S_CALC: begin
          quo_q   <= prod[PROD_W-1:DIV_SHIFT];
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          if (out_free) begin
            if (op_q == twe_pkg::OP_TICK) begin
              state_q <= S_REPORT;
            end else begin
              out_rsp_q.task_id_out <= id_q;
              out_rsp_q.last        <= 1'b1;
              if (op_q == twe_pkg::OP_ADD) begin
                out_rsp_q.event_res <= (chain[NUM_TIMERS].match || !chain[NUM_TIMERS].free)
                                       ? twe_pkg::EV_REJECTED : twe_pkg::EV_DONE;
              end else begin
                out_rsp_q.event_res <= chain[NUM_TIMERS].match
                                       ? twe_pkg::EV_DONE : twe_pkg::EV_UNKNOWN;
              end
              state_q <= S_IDLE;
            end
          end
        end
        S_REPORT: begin
          if (out_free) begin
            if (chain[NUM_TIMERS].rpt_hit) begin
              out_rsp_q.task_id_out <= chain[NUM_TIMERS].rpt_id;
              out_rsp_q.event_res   <= chain[NUM_TIMERS].rpt_ev;
              out_rsp_q.last        <= 1'b0;
            end else begin
              out_rsp_q.task_id_out <= '0;
              out_rsp_q.event_res   <= twe_pkg::EV_DONE;
              out_rsp_q.last        <= 1'b1;
              state_q               <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

/* sim/timer_wheel_expiry_unit_test.sv */
// ----------------------------------------------------------------------------
// timer_wheel_expiry_unit_test
// Drives add, refresh, cancel and tick requests into the timer wheel and
// checks every result against a timer-table prediction kept in the bench.
// A short directed run covers the corner cases. A random run follows, with
// a table flush, a full table and a tick that expires every timer at once.
// Both sides idle and stall in random bursts.
// ----------------------------------------------------------------------------
module timer_wheel_expiry_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_T = twe_pkg::NUM_TIMERS_DEF;
  localparam int WHEEL = twe_pkg::WHEEL_SLOTS_DEF;

  typedef struct {
    twe_pkg::in_req_t req;
    bit               drain;
  } stim_item_t;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  twe_pkg::in_req_t   in_req    = '0;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  twe_pkg::out_rsp_t  out_rsp;

  stim_item_t         pending_req_q[$];
  twe_pkg::out_rsp_t  rsp_expect_q[$];
  int unsigned        fail_count = 0;
  int unsigned        cyc = 0;
  int unsigned        send_gap = 0;
  int unsigned        stall_left = 0;

  logic                      tmr_live [NUM_T] = '{default: 1'b0};
  logic [twe_pkg::ID_W-1:0]  tmr_id   [NUM_T];
  logic [twe_pkg::REM_W-1:0] tmr_left [NUM_T];
  logic [twe_pkg::REM_W-1:0] tmr_dist [NUM_T];
  logic                      tmr_cxl  [NUM_T];

  timer_wheel_expiry_unit DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  function automatic logic [twe_pkg::REM_W-1:0] wheel_distance(
      logic [twe_pkg::TMO_W-1:0] tmo);
    int unsigned d;
    d = int'(tmo) % WHEEL;
    if (d == 0) begin
      d = WHEEL;
    end
    return twe_pkg::REM_W'(d);
  endfunction

  function automatic bit idling_on();
    return (pending_req_q.size() >= 40) && (cyc[7:6] != 2'b00);
  endfunction

  task automatic push_expected(logic [twe_pkg::ID_W-1:0] id, twe_pkg::event_e ev,
                               logic last);
    twe_pkg::out_rsp_t r;
    r.task_id_out = id;
    r.event_res   = ev;
    r.last        = last;
    rsp_expect_q  = {rsp_expect_q, r};
  endtask

  task automatic predict_timer_results(twe_pkg::in_req_t req);
    int hit;
    int slot;
    hit  = -1;
    slot = -1;
    for (int i = 0; i < NUM_T; i++) begin
      if (tmr_live[i] && tmr_id[i] == req.task_id) begin
        hit = i;
      end
      if (!tmr_live[i] && slot < 0) begin
        slot = i;
      end
    end
    case (twe_pkg::opcode_e'(req.opcode))
      twe_pkg::OP_TICK: begin
        for (int i = 0; i < NUM_T; i++) begin
          if (tmr_live[i]) begin
            if (tmr_left[i] != '0) begin
              tmr_left[i] = tmr_left[i] - 1'b1;
            end
            if (tmr_left[i] == '0) begin
              tmr_live[i] = 1'b0;
              push_expected(tmr_id[i],
                            tmr_cxl[i] ? twe_pkg::EV_CANCELED : twe_pkg::EV_FIRED, 1'b0);
            end
          end
        end
        push_expected('0, twe_pkg::EV_DONE, 1'b1);
      end
      twe_pkg::OP_ADD: begin
        if (hit >= 0 || slot < 0) begin
          push_expected(req.task_id, twe_pkg::EV_REJECTED, 1'b1);
        end else begin
          tmr_live[slot] = 1'b1;
          tmr_id[slot]   = req.task_id;
          tmr_dist[slot] = wheel_distance(req.timeout_ticks);
          tmr_left[slot] = tmr_dist[slot];
          tmr_cxl[slot]  = 1'b0;
          push_expected(req.task_id, twe_pkg::EV_DONE, 1'b1);
        end
      end
      default: begin
        if (hit < 0) begin
          push_expected(req.task_id, twe_pkg::EV_UNKNOWN, 1'b1);
        end else begin
          if (twe_pkg::opcode_e'(req.opcode) == twe_pkg::OP_REFRESH) begin
            if (tmr_dist[hit] > tmr_left[hit]) begin
              tmr_left[hit] = tmr_dist[hit];
            end
          end else begin
            tmr_cxl[hit] = 1'b1;
          end
          push_expected(req.task_id, twe_pkg::EV_DONE, 1'b1);
        end
      end
    endcase
  endtask

  task automatic check_result(twe_pkg::out_rsp_t got);
    twe_pkg::out_rsp_t want;
    if (rsp_expect_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("unexpected result: id %h ev %0d last %0b",
                 got.task_id_out, got.event_res, got.last);
      end
    end else begin
      want = rsp_expect_q.pop_front();
      if (got.task_id_out !== want.task_id_out || got.event_res !== want.event_res ||
          got.last !== want.last) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("result mismatch: expected id %h ev %0d last %0b, got id %h ev %0d last %0b",
                   want.task_id_out, want.event_res, want.last,
                   got.task_id_out, got.event_res, got.last);
        end
      end
    end
  endtask

  task automatic queue_request(twe_pkg::opcode_e op, logic [twe_pkg::ID_W-1:0] id,
                               logic [twe_pkg::TMO_W-1:0] tmo, bit drain = 1'b0);
    stim_item_t it;
    it.req.opcode        = op;
    it.req.task_id       = id;
    it.req.timeout_ticks = tmo;
    it.drain             = drain;
    pending_req_q        = {pending_req_q, it};
  endtask

  always @(posedge clk or negedge rst_n) begin
    stim_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_req   <= '0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_timer_results(in_req);
      end
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_req_q.size() == 0 ||
                     (pending_req_q[0].drain && rsp_expect_q.size() != 0)) begin
          in_valid <= 1'b0;
        end else if (idling_on() && $urandom_range(0, 9) == 0) begin
          send_gap <= $urandom_range(0, 8);
          in_valid <= 1'b0;
        end else begin
          it = pending_req_q.pop_front();
          in_valid <= 1'b1;
          in_req   <= it.req;
        end
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        check_result(out_rsp);
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else if (idling_on() && $urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(0, 8);
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [twe_pkg::ID_W-1:0]  id_pool [12];
    logic [twe_pkg::ID_W-1:0]  id;
    logic [twe_pkg::TMO_W-1:0] tmo;
    int unsigned               pick;
    bit                        flushed;
    flushed = 1'b0;

    queue_request(twe_pkg::OP_TICK, '0, '0);
    queue_request(twe_pkg::OP_ADD, '0, 10'd0);
    queue_request(twe_pkg::OP_ADD, '1, 10'd1023);
    queue_request(twe_pkg::OP_ADD, '1, 10'd5);
    queue_request(twe_pkg::OP_ADD, 64'h8000_0000_0000_0001, 10'd1);
    queue_request(twe_pkg::OP_REFRESH, 64'h5555_5555_5555_5555, 10'd0);
    queue_request(twe_pkg::OP_CANCEL, 64'hAAAA_AAAA_AAAA_AAAA, 10'd0);
    queue_request(twe_pkg::OP_CANCEL, '1, 10'd0);
    queue_request(twe_pkg::OP_CANCEL, '1, 10'd0);
    queue_request(twe_pkg::OP_REFRESH, '1, 10'd0);
    queue_request(twe_pkg::OP_TICK, '0, '0);
    queue_request(twe_pkg::OP_REFRESH, '1, 10'd1023);
    queue_request(twe_pkg::OP_ADD, 64'h1, 10'd1020);
    queue_request(twe_pkg::OP_ADD, 64'h2, 10'd59);
    queue_request(twe_pkg::OP_TICK, '0, '0);
    queue_request(twe_pkg::OP_TICK, '1, 10'd1023);
    queue_request(twe_pkg::OP_TICK, '0, '0);
    queue_request(twe_pkg::OP_REFRESH, '0, 10'd0);
    queue_request(twe_pkg::OP_ADD, 64'h5555_5555_5555_5555, 10'd512);
    queue_request(twe_pkg::OP_CANCEL, 64'h1, 10'd0);
    queue_request(twe_pkg::OP_TICK, 64'hAAAA_AAAA_AAAA_AAAA, 10'd682);

    foreach (id_pool[k]) begin
      id_pool[k] = {$urandom, $urandom};
    end
    id_pool[0] = '0;
    id_pool[1] = '1;

    queue_request(twe_pkg::OP_TICK, '0, '0, 1'b1);
    while (pending_req_q.size() < 220) begin
      if (!flushed && pending_req_q.size() > 90) begin
        flushed = 1'b1;
        repeat (WHEEL) begin
          queue_request(twe_pkg::OP_TICK, {$urandom, $urandom}, twe_pkg::TMO_W'($urandom));
        end
        for (int k = 0; k <= NUM_T; k++) begin
          queue_request(twe_pkg::OP_ADD, {$urandom, $urandom},
                        twe_pkg::TMO_W'(WHEEL * $urandom_range(0, 16) + 1), k == 0);
        end
        queue_request(twe_pkg::OP_TICK, '0, '0);
      end else if ($urandom_range(0, 29) == 0) begin
        for (int k = 0; k <= NUM_T; k++) begin
          queue_request(twe_pkg::OP_ADD, {$urandom, $urandom},
                        twe_pkg::TMO_W'(WHEEL * $urandom_range(0, 15) +
                                        $urandom_range(1, 3)));
        end
        repeat (2) queue_request(twe_pkg::OP_TICK, '0, '0);
      end else begin
        if ($urandom_range(0, 19) == 0) begin
          id_pool[$urandom_range(0, 11)] = {$urandom, $urandom};
        end
        id   = ($urandom_range(0, 9) < 8) ? id_pool[$urandom_range(0, 11)]
                                          : {$urandom, $urandom};
        tmo  = ($urandom_range(0, 9) < 7) ? twe_pkg::TMO_W'(WHEEL * $urandom_range(0, 16) +
                                                           $urandom_range(1, 6))
                                          : twe_pkg::TMO_W'($urandom_range(0, 1023));
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          queue_request(twe_pkg::OP_TICK, {$urandom, $urandom}, twe_pkg::TMO_W'($urandom));
        end else if (pick < 65) begin
          queue_request(twe_pkg::OP_ADD, id, tmo);
        end else if (pick < 82) begin
          queue_request(twe_pkg::OP_REFRESH, id, tmo);
        end else begin
          queue_request(twe_pkg::OP_CANCEL, id, tmo);
        end
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_req_q.size() != 0 || in_valid) begin
      @(posedge clk);
    end
    while (rsp_expect_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);

    if (fail_count == 0 && rsp_expect_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
